// ===== rtl/core/ld64_pkg.sv =====
// shared types and constants for the 64 by 32 long divider
package ld64_pkg;

	localparam int unsigned DIVIDEND_W = 64;
	localparam int unsigned DIVISOR_W  = 32;
	localparam int unsigned HALF_W     = DIVIDEND_W / 2;
	localparam int unsigned STEPS      = DIVIDEND_W;
	localparam int unsigned STEP_W     = $clog2(STEPS);

	typedef enum logic [1:0] {
		MODE_UNSIGNED = 2'd0,
		MODE_SIGNED   = 2'd1,
		MODE_NARROW   = 2'd2
	} mode_t;

	typedef logic [DIVIDEND_W-1:0] dword_t;
	typedef logic [DIVISOR_W-1:0]  sword_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== rtl/core/ld64_ifs.sv =====
// request and response channel interfaces of the long divider
interface ld64_in_if;
	import ld64_pkg::*;

	logic      valid;
	logic      ready;
	logic [1:0] mode;
	dword_t    dividend;
	sword_t    divisor;

	modport source (output valid, output mode, output dividend, output divisor, input ready);
	modport sink (input valid, input mode, input dividend, input divisor, output ready);
endinterface

interface ld64_out_if;
	import ld64_pkg::*;

	logic   valid;
	logic   ready;
	dword_t quotient;
	sword_t remainder;

	modport source (output valid, output quotient, output remainder, input ready);
	modport sink (input valid, input quotient, input remainder, output ready);
endinterface

// ===== rtl/core/ld64_divu.sv =====
// radix-2 restoring divider core, one subtract and compare per cycle
module ld64_divu (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  ld64_pkg::dword_t      num,
	input  ld64_pkg::sword_t      den,
	output ld64_pkg::div_status_t status,
	output ld64_pkg::dword_t      quo,
	output ld64_pkg::sword_t      rem
);
	import ld64_pkg::*;

	typedef enum logic {
		C_IDLE,
		C_RUN
	} core_state_t;

	core_state_t         state_q;
	logic [STEP_W-1:0]   cnt_q;
	logic                done_q;
	sword_t              rem_q;
	dword_t              num_q;
	sword_t              den_q;

	logic [DIVISOR_W:0]   shifted;
	logic [DIVISOR_W+1:0] trial;
	logic                 qbit;
	sword_t               next_rem;

	assign shifted  = {rem_q, num_q[DIVIDEND_W-1]};
	assign trial    = {1'b0, shifted} - {2'b00, den_q};
	assign qbit     = ~trial[DIVISOR_W+1];
	assign next_rem = qbit ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_RUN;
						cnt_q   <= '0;
					end
				end
				C_RUN: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(STEPS - 1)) begin
						state_q <= C_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (state_q == C_RUN) begin
			rem_q <= next_rem;
			num_q <= {num_q[DIVIDEND_W-2:0], qbit};
		end
	end

	assign status.busy = (state_q == C_RUN);
	assign status.done = done_q;
	assign quo         = num_q;
	assign rem         = rem_q;

endmodule

// ===== rtl/core/long_division_64_by_32_top.sv =====
// long divider top: operands latched on request, core started through start_q,
// 64 shift-subtract steps, then sign fix-up as the result is registered
// not ready while a request is in flight or a result waits
// arst_n clears the sequencers; operand and result registers are not reset
module long_division_64_by_32_top (
	input  logic        clk,
	input  logic        arst_n,
	ld64_in_if.sink     in_req,
	ld64_out_if.source  out_rsp
);
	import ld64_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_OUT
	} top_state_t;

	top_state_t  state_q;
	logic        start_q;
	logic        valid_q;
	dword_t      nmag_q;
	sword_t      dmag_q;
	logic        neg_q;
	logic        zero_q;
	logic        ovf_q;
	logic        narrow_q;
	dword_t      quotient_q;
	sword_t      remainder_q;

	logic        take;
	logic        is_signed;
	dword_t      nmag;
	sword_t      dmag;
	logic        neg;
	div_status_t status;
	dword_t      core_quo;
	sword_t      core_rem;
	dword_t      qmag;
	dword_t      qfinal;

	assign take      = in_req.valid && in_req.ready;
	assign is_signed = (in_req.mode == MODE_SIGNED);

	always_comb begin
		nmag = in_req.dividend;
		dmag = in_req.divisor;
		neg  = 1'b0;
		if (is_signed) begin
			if (in_req.dividend[DIVIDEND_W-1]) begin
				nmag = ~in_req.dividend + dword_t'(1);
			end
			if (in_req.divisor[DIVISOR_W-1]) begin
				dmag = ~in_req.divisor + sword_t'(1);
			end
			neg = in_req.dividend[DIVIDEND_W-1] ^ in_req.divisor[DIVISOR_W-1];
		end
	end

	ld64_divu u_divu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (nmag_q),
		.den    (dmag_q),
		.status (status),
		.quo    (core_quo),
		.rem    (core_rem)
	);

	// zero divisor gives an all-ones magnitude before sign handling
	assign qmag   = zero_q ? '1 : core_quo;
	assign qfinal = neg_q ? (~qmag + dword_t'(1)) : qmag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_DIV;
						start_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (status.done) begin
						state_q <= S_OUT;
						valid_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (out_rsp.ready) begin
						state_q <= S_IDLE;
						valid_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			nmag_q   <= nmag;
			dmag_q   <= dmag;
			neg_q    <= neg;
			zero_q   <= (in_req.divisor == '0);
			ovf_q    <= (in_req.mode == MODE_NARROW) &&
				(in_req.dividend[DIVIDEND_W-1:HALF_W] >= in_req.divisor);
			narrow_q <= (in_req.mode == MODE_NARROW);
		end
		if (state_q == S_DIV && status.done) begin
			if (ovf_q) begin
				quotient_q  <= {{HALF_W{1'b0}}, {HALF_W{1'b1}}};
				remainder_q <= '1;
			end else if (narrow_q) begin
				quotient_q  <= {{HALF_W{1'b0}}, qfinal[HALF_W-1:0]};
				remainder_q <= zero_q ? '1 : core_rem;
			end else begin
				quotient_q  <= qfinal;
				remainder_q <= zero_q ? '1 : core_rem;
			end
		end
	end

	assign in_req.ready      = (state_q == S_IDLE);
	assign out_rsp.valid     = valid_q;
	assign out_rsp.quotient  = quotient_q;
	assign out_rsp.remainder = remainder_q;

`ifndef ASSERT_OFF
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> (state_q == S_DIV))
		else $error("core finished outside of a division");

	a_start_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (start_q && !status.busy))
		else $error("accepted request did not start the core");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_rsp.valid && in_req.ready))
		else $error("ready while a result is pending");

	a_narrow_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_rsp.valid && narrow_q) |-> (out_rsp.quotient[DIVIDEND_W-1:HALF_W] == '0))
		else $error("narrow quotient exceeds half width");
`endif

endmodule
